@@ hw/rtl/nsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nsa_pkg
// Shared types, codes and constants of the MIDI note slot allocator.
// ----------------------------------------------------------------------------
package nsa_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int NUM_PORTS     = 2;

    localparam int PORTS_W = 2;
    localparam int CHAN_W  = 4;
    localparam int DATA_W  = 7;
    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 32;

    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_CTRL     = 4'hB;

    typedef enum logic [1:0] {
        REQ_PLAY = 2'd0,
        REQ_STOP = 2'd1,
        REQ_CC   = 2'd2,
        REQ_ALL  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        OC_SENT       = 2'd0,
        OC_PORT_OFF   = 2'd1,
        OC_FULL       = 2'd2,
        OC_NOT_ACTIVE = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_REL_A,
        ST_REL_B,
        ST_REL_C
    } state_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic                port;
        logic [CHAN_W-1:0]   channel;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   controller;
        logic [DATA_W-1:0]   value;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   time_stamp;
    } req_t;

    typedef struct packed {
        logic                send_valid;
        logic [7:0]          status_byte;
        logic [DATA_W-1:0]   data_one;
        logic [DATA_W-1:0]   data_two;
        logic                out_port;
        logic [TIME_W-1:0]   out_time;
        logic [SLOT_W-1:0]   handle;
        outcome_t            outcome;
        logic                last;
    } result_t;

    // per-slot record held in the slot memory
    typedef struct packed {
        logic                active;
        logic [CHAN_W-1:0]   channel;
        logic [DATA_W-1:0]   key;
        logic                port;
    } slot_info_t;

endpackage

@@ hw/rtl/nsa_ram.sv @@
// ----------------------------------------------------------------------------
// nsa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/nsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// nsa_ctrl
// Request sequencer: slot memory and next/prev link memories, list pointers,
// read-modify-write of the ordered slot list.
// ----------------------------------------------------------------------------
module nsa_ctrl #(
    parameter int NUM_SLOTS = nsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  nsa_pkg::req_t                in_req,
    input  logic [nsa_pkg::PORTS_W-1:0]  port_enabled,
    input  logic                         out_free,
    output logic                         emit,
    output nsa_pkg::result_t             res
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    // one spare bit so that NUM_SLOTS itself is representable in the compare
    localparam int CMP_W = ((IDX_W > nsa_pkg::SLOT_W) ? IDX_W : nsa_pkg::SLOT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    nsa_pkg::state_t      state_reg, state_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [IDX_W-1:0]     back_reg, back_next;
    logic [IDX_W-1:0]     oldest_reg, oldest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     init_reg, init_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    nsa_pkg::req_t        req_reg, req_next;
    logic                 range_reg, range_next;

    // memory ports
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    nsa_pkg::slot_info_t  info_rd;
    logic [IDX_W-1:0]     link_n, link_p;
    logic                 info_we;
    logic [IDX_W-1:0]     info_waddr;
    nsa_pkg::slot_info_t  info_wdata;
    logic                 nx_we, pv_we;
    logic [IDX_W-1:0]     nx_waddr, nx_wdata, pv_waddr, pv_wdata;

    logic [CMP_W-1:0]     in_slot_wide;
    logic                 in_range;
    logic [CMP_W-1:0]     cur_wide;
    logic                 port_ok;
    logic                 rel_done;
    logic                 play_ok;

    nsa_ram #(.WIDTH($bits(nsa_pkg::slot_info_t)), .DEPTH(NUM_SLOTS), .AW(IDX_W)) u_info (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (info_rd),
        .wr_en   (info_we),
        .wr_addr (info_waddr),
        .wr_data (info_wdata)
    );

    nsa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS), .AW(IDX_W)) u_next (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_n),
        .wr_en   (nx_we),
        .wr_addr (nx_waddr),
        .wr_data (nx_wdata)
    );

    nsa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS), .AW(IDX_W)) u_prev (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_p),
        .wr_en   (pv_we),
        .wr_addr (pv_waddr),
        .wr_data (pv_wdata)
    );

    assign in_slot_wide = CMP_W'(in_req.slot);
    assign in_range     = in_slot_wide < CMP_W'(NUM_SLOTS);
    assign cur_wide     = CMP_W'(cur_reg);
    assign port_ok      = (32'(req_reg.port) < nsa_pkg::NUM_PORTS)
                          && port_enabled[req_reg.port];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nsa_pkg::ST_INIT;
            front_reg  <= '0;
            back_reg   <= LAST_IDX;
            oldest_reg <= '0;
            count_reg  <= '0;
            init_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            init_reg   <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        req_reg   <= req_next;
        range_reg <= range_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        init_next   = init_reg;
        cur_next    = cur_reg;
        req_next    = req_reg;
        range_next  = range_reg;

        in_ready   = 1'b0;
        emit       = 1'b0;
        res        = '0;
        res.out_time = req_reg.time_stamp;
        res.last   = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        info_we    = 1'b0;
        info_waddr = cur_reg;
        info_wdata = '0;
        nx_we      = 1'b0;
        nx_waddr   = cur_reg;
        nx_wdata   = cur_reg;
        pv_we      = 1'b0;
        pv_waddr   = cur_reg;
        pv_wdata   = cur_reg;
        rel_done   = 1'b0;
        play_ok    = 1'b0;

        case (state_reg)
            nsa_pkg::ST_INIT:
            begin
                // build the ascending ring, all slots free
                info_we    = 1'b1;
                info_waddr = init_reg;
                nx_we      = 1'b1;
                nx_waddr   = init_reg;
                nx_wdata   = (init_reg == LAST_IDX) ? '0 : init_reg + 1'b1;
                pv_we      = 1'b1;
                pv_waddr   = init_reg;
                pv_wdata   = (init_reg == '0) ? LAST_IDX : init_reg - 1'b1;
                init_next  = init_reg + 1'b1;
                if (init_reg == LAST_IDX)
                begin
                    state_next = nsa_pkg::ST_IDLE;
                end
            end

            nsa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = in_req;
                    range_next = in_range;
                    rd_en      = 1'b1;
                    case (in_req.req_type)
                        nsa_pkg::REQ_STOP: rd_addr = in_slot_wide[IDX_W-1:0];
                        nsa_pkg::REQ_ALL:  rd_addr = oldest_reg;
                        default:           rd_addr = front_reg;
                    endcase
                    cur_next   = rd_addr;
                    state_next = nsa_pkg::ST_DECIDE;
                end
            end

            nsa_pkg::ST_DECIDE:
            begin
                case (req_reg.req_type)
                    nsa_pkg::REQ_PLAY:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = nsa_pkg::ST_IDLE;
                            if (!port_ok)
                            begin
                                res.outcome = nsa_pkg::OC_PORT_OFF;
                            end
                            else if (info_rd.active)
                            begin
                                res.outcome = nsa_pkg::OC_FULL;
                            end
                            else
                            begin
                                play_ok         = 1'b1;
                                res.send_valid  = 1'b1;
                                res.status_byte = {nsa_pkg::CMD_NOTE_ON, req_reg.channel};
                                res.data_one    = req_reg.key;
                                res.data_two    = req_reg.value;
                                res.out_port    = req_reg.port;
                                res.handle      = cur_wide[nsa_pkg::SLOT_W-1:0];
                                res.outcome     = nsa_pkg::OC_SENT;
                                info_we         = 1'b1;
                                info_wdata      = '{active: 1'b1, channel: req_reg.channel,
                                                    key: req_reg.key, port: req_reg.port};
                                // front slot becomes the back: ring rotates
                                front_next      = link_n;
                                back_next       = cur_reg;
                                count_next      = count_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    oldest_next = cur_reg;
                                end
                            end
                        end
                    end

                    nsa_pkg::REQ_CC:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = nsa_pkg::ST_IDLE;
                            if (port_ok)
                            begin
                                res.send_valid  = 1'b1;
                                res.status_byte = {nsa_pkg::CMD_CTRL, req_reg.channel};
                                res.data_one    = req_reg.controller;
                                res.data_two    = req_reg.value;
                                res.out_port    = req_reg.port;
                                res.outcome     = nsa_pkg::OC_SENT;
                            end
                            else
                            begin
                                res.outcome = nsa_pkg::OC_PORT_OFF;
                            end
                        end
                    end

                    nsa_pkg::REQ_STOP:
                    begin
                        if (range_reg && info_rd.active)
                        begin
                            state_next = nsa_pkg::ST_REL_A;
                        end
                        else if (out_free)
                        begin
                            emit        = 1'b1;
                            res.handle  = req_reg.slot;
                            res.outcome = nsa_pkg::OC_NOT_ACTIVE;
                            state_next  = nsa_pkg::ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = nsa_pkg::ST_REL_A;
                        end
                        else if (out_free)
                        begin
                            emit        = 1'b1;
                            res.outcome = nsa_pkg::OC_SENT;
                            state_next  = nsa_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            nsa_pkg::ST_REL_A:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    res.send_valid  = 1'b1;
                    res.status_byte = {nsa_pkg::CMD_NOTE_OFF, info_rd.channel};
                    res.data_one    = info_rd.key;
                    res.data_two    = '0;
                    res.out_port    = info_rd.port;
                    res.handle      = cur_wide[nsa_pkg::SLOT_W-1:0];
                    res.outcome     = nsa_pkg::OC_SENT;
                    res.last        = (req_reg.req_type == nsa_pkg::REQ_STOP)
                                      || (count_reg == CNT_W'(1));
                    info_we         = 1'b1;
                    if ((cur_reg != front_reg) && (cur_reg != back_reg))
                    begin
                        // unlink: next[p] = n, prev[n] = p
                        nx_we      = 1'b1;
                        nx_waddr   = link_p;
                        nx_wdata   = link_n;
                        pv_we      = 1'b1;
                        pv_waddr   = link_n;
                        pv_wdata   = link_p;
                        state_next = nsa_pkg::ST_REL_B;
                    end
                    else
                    begin
                        // back slot going to the front leaves the ring as it is
                        if (cur_reg != front_reg)
                        begin
                            front_next = cur_reg;
                            back_next  = link_p;
                        end
                        rel_done = 1'b1;
                    end
                end
            end

            nsa_pkg::ST_REL_B:
            begin
                nx_we      = 1'b1;
                nx_waddr   = back_reg;
                nx_wdata   = cur_reg;
                pv_we      = 1'b1;
                pv_waddr   = cur_reg;
                pv_wdata   = back_reg;
                state_next = nsa_pkg::ST_REL_C;
            end

            nsa_pkg::ST_REL_C:
            begin
                nx_we      = 1'b1;
                nx_waddr   = cur_reg;
                nx_wdata   = front_reg;
                pv_we      = 1'b1;
                pv_waddr   = front_reg;
                pv_wdata   = cur_reg;
                front_next = cur_reg;
                rel_done   = 1'b1;
            end

            default:
            begin
                state_next = nsa_pkg::ST_IDLE;
            end
        endcase

        if (rel_done)
        begin
            count_next = count_reg - 1'b1;
            if (cur_reg == oldest_reg)
            begin
                oldest_next = link_n;
            end
            if ((req_reg.req_type == nsa_pkg::REQ_ALL) && (count_reg > CNT_W'(1)))
            begin
                // actives are contiguous: the next one is the following slot
                rd_en      = 1'b1;
                rd_addr    = link_n;
                cur_next   = link_n;
                state_next = nsa_pkg::ST_REL_A;
            end
            else
            begin
                state_next = nsa_pkg::ST_IDLE;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_SLOTS))
        else $error("active count above pool size");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result produced while output register busy");

    a_relink_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nsa_pkg::ST_REL_B) |-> (cur_reg != front_reg) && (cur_reg != back_reg))
        else $error("relink of a slot at the list ends");

    a_play_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        play_ok |-> (count_reg < CNT_W'(NUM_SLOTS)))
        else $error("slot taken from a full pool");

    a_play_back: assert property (@(posedge clk) disable iff (!rst_n)
        play_ok |=> (back_reg == $past(cur_reg)) && (count_reg != '0))
        else $error("played slot not at the back");
`endif

endmodule

@@ hw/rtl/midi_note_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// midi_note_slot_allocator
// Note slot pool with an ordered free/active list and MIDI message output.
// ----------------------------------------------------------------------------
// After reset the block builds its slot list in memory and takes no request
// meanwhile; configuration writes are taken at any time. Requests go one at
// a time: play, control change and every rejected request pass through the
// registered read of the slot memories and the decide state; a stop adds the
// release state REL_A, and a stop of a slot in the middle of the list also
// the relink states REL_B and REL_C, as each link memory has a single write
// port; stop-all releases the active slots one after another in the same way.
// Results are also held while the downstream side holds tready low. A new
// request is accepted while the last result still waits in the output register.
module midi_note_slot_allocator #(
    parameter int NUM_SLOTS = nsa_pkg::NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // port, channel, key, controller, value, slot, time_stamp (low to high)
    input  logic [63:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // status_byte, data_one, data_two, out_port, out_time, handle, outcome, pad
    output logic [63:0] m_tdata,
    // send_valid
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    logic [nsa_pkg::PORTS_W-1:0] port_en_reg;
    logic                        out_valid_reg;
    nsa_pkg::result_t            out_reg;
    nsa_pkg::req_t               in_req;
    nsa_pkg::result_t            res;
    logic                        emit;
    logic                        out_free;

    assign in_req.req_type   = nsa_pkg::req_kind_t'(s_tuser);
    assign in_req.port       = s_tdata[0];
    assign in_req.channel    = s_tdata[4:1];
    assign in_req.key        = s_tdata[11:5];
    assign in_req.controller = s_tdata[18:12];
    assign in_req.value      = s_tdata[25:19];
    assign in_req.slot       = s_tdata[31:26];
    assign in_req.time_stamp = s_tdata[63:32];

    assign out_free = !out_valid_reg || m_tready;

    nsa_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req       (in_req),
        .port_enabled (port_en_reg),
        .out_free     (out_free),
        .emit         (emit),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_en_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                port_en_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.outcome, out_reg.handle, out_reg.out_time,
                       out_reg.out_port, out_reg.data_two, out_reg.data_one,
                       out_reg.status_byte};
    assign m_tuser  = out_reg.send_valid;
    assign m_tlast  = out_reg.last;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midi_note_slot_allocator. Requests go in over the
// request stream with random gaps, and the result stream is stalled at random,
// except in a steady phase. A behavioral copy of the slot list predicts every
// result, and each result is checked field by field against the oldest
// prediction. Directed tests cover disabled ports, field extremes, port mask
// changes and a full pool. Random phases under several port masks follow.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS  = nsa_pkg::NUM_SLOTS_DEF;
    localparam int CH_W   = nsa_pkg::CHAN_W;
    localparam int DT_W   = nsa_pkg::DATA_W;
    localparam int SL_W   = nsa_pkg::SLOT_W;
    localparam int TM_W   = nsa_pkg::TIME_W;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // port, channel, key, controller, value, slot, time_stamp
    logic [1:0]  s_tuser;     // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;     // status_byte, data_one, data_two, out_port, out_time,
                              // handle, outcome, pad
    logic [0:0]  m_tuser;     // send_valid
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;

    midi_note_slot_allocator #(
        .NUM_SLOTS (SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted slot pool
    logic            slot_on   [SLOTS];
    logic [CH_W-1:0] slot_chan [SLOTS];
    logic [DT_W-1:0] slot_note [SLOTS];
    logic            slot_prt  [SLOTS];
    logic [SL_W-1:0] link_fwd  [SLOTS];
    logic [SL_W-1:0] link_bwd  [SLOTS];
    logic [SL_W-1:0] pool_head;
    logic [1:0]      ports_on;

    nsa_pkg::result_t pending_msgs[$];

    int  err_count;
    int  result_count;
    bit  quiet_run;
    int  n_req, n_on, n_off, n_cc, n_all, n_port_off, n_full, n_idle_stop;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Timeout with %0d results still expected", pending_msgs.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(string msg);
        if (err_count < 40)
            $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    task automatic release_note(int s, logic [TM_W-1:0] ts, logic fin);
        nsa_pkg::result_t r;
        int      p;
        int      n;
        int      b;
        r             = '0;
        r.send_valid  = 1'b1;
        r.status_byte = {nsa_pkg::CMD_NOTE_OFF, slot_chan[s]};
        r.data_one    = slot_note[s];
        r.out_port    = slot_prt[s];
        r.out_time    = ts;
        r.handle      = SL_W'(s);
        r.outcome     = nsa_pkg::OC_SENT;
        r.last        = fin;
        pending_msgs.push_back(r);
        n_off++;
        slot_on[s] = 1'b0;
        // freed slot goes in front of the current head
        if (s != pool_head)
        begin
            p = link_bwd[s];
            n = link_fwd[s];
            link_fwd[p] = SL_W'(n);
            link_bwd[n] = SL_W'(p);
            b = link_bwd[pool_head];
            link_fwd[b] = SL_W'(s);
            link_bwd[s] = SL_W'(b);
            link_fwd[s] = pool_head;
            link_bwd[pool_head] = SL_W'(s);
            pool_head = SL_W'(s);
        end
    endtask

    task automatic predict_request(nsa_pkg::req_kind_t kind, logic prt,
                                   logic [CH_W-1:0] ch, logic [DT_W-1:0] note,
                                   logic [DT_W-1:0] ctl, logic [DT_W-1:0] val,
                                   logic [SL_W-1:0] sl, logic [TM_W-1:0] ts);
        nsa_pkg::result_t r;
        int      held[$];
        int      s;
        r          = '0;
        r.out_time = ts;
        r.outcome  = nsa_pkg::OC_SENT;
        r.last     = 1'b1;
        n_req++;
        case (kind)
            nsa_pkg::REQ_PLAY:
            begin
                if (!ports_on[prt])
                begin
                    r.outcome = nsa_pkg::OC_PORT_OFF;
                    n_port_off++;
                end
                else if (slot_on[pool_head])
                begin
                    r.outcome = nsa_pkg::OC_FULL;
                    n_full++;
                end
                else
                begin
                    s             = pool_head;
                    r.send_valid  = 1'b1;
                    r.status_byte = {nsa_pkg::CMD_NOTE_ON, ch};
                    r.data_one    = note;
                    r.data_two    = val;
                    r.out_port    = prt;
                    r.handle      = SL_W'(s);
                    slot_on[s]    = 1'b1;
                    slot_chan[s]  = ch;
                    slot_note[s]  = note;
                    slot_prt[s]   = prt;
                    pool_head     = link_fwd[s];
                    n_on++;
                end
                pending_msgs.push_back(r);
            end
            nsa_pkg::REQ_STOP:
            begin
                if (!slot_on[sl])
                begin
                    r.outcome = nsa_pkg::OC_NOT_ACTIVE;
                    r.handle  = sl;
                    pending_msgs.push_back(r);
                    n_idle_stop++;
                end
                else
                    release_note(sl, ts, 1'b1);
            end
            nsa_pkg::REQ_CC:
            begin
                if (!ports_on[prt])
                begin
                    r.outcome = nsa_pkg::OC_PORT_OFF;
                    n_port_off++;
                end
                else
                begin
                    r.send_valid  = 1'b1;
                    r.status_byte = {nsa_pkg::CMD_CTRL, ch};
                    r.data_one    = ctl;
                    r.data_two    = val;
                    r.out_port    = prt;
                    n_cc++;
                end
                pending_msgs.push_back(r);
            end
            default:
            begin
                n_all++;
                // oldest first: walk from the head, free slots come before active
                s = pool_head;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_on[s])
                        held.push_back(s);
                    s = link_fwd[s];
                end
                if (held.size() == 0)
                    pending_msgs.push_back(r);
                for (int k = 0; k < held.size(); k++)
                    release_note(held[k], ts, k == held.size() - 1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        nsa_pkg::result_t got;
        nsa_pkg::result_t want;
        string   bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.send_valid  = m_tuser[0];
            got.status_byte = m_tdata[7:0];
            got.data_one    = m_tdata[14:8];
            got.data_two    = m_tdata[21:15];
            got.out_port    = m_tdata[22];
            got.out_time    = m_tdata[54:23];
            got.handle      = m_tdata[60:55];
            got.outcome     = nsa_pkg::outcome_t'(m_tdata[62:61]);
            got.last        = m_tlast;
            result_count++;
            if (pending_msgs.size() == 0)
                report_mismatch($sformatf("result %0d with nothing expected: %h",
                                          result_count, got));
            else
            begin
                want = pending_msgs.pop_front();
                bad  = "";
                if (got.send_valid !== want.send_valid)   bad = {bad, " send_valid"};
                if (got.status_byte !== want.status_byte) bad = {bad, " status_byte"};
                if (got.data_one !== want.data_one)       bad = {bad, " data_one"};
                if (got.data_two !== want.data_two)       bad = {bad, " data_two"};
                if (got.out_port !== want.out_port)       bad = {bad, " out_port"};
                if (got.out_time !== want.out_time)       bad = {bad, " out_time"};
                if (got.handle !== want.handle)           bad = {bad, " handle"};
                if (got.outcome !== want.outcome)         bad = {bad, " outcome"};
                if (got.last !== want.last)               bad = {bad, " last"};
                if (bad != "")
                    report_mismatch($sformatf("result %0d:%s exp %h got %h",
                                              result_count, bad, want, got));
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready = quiet_run ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------
    task automatic send_request(nsa_pkg::req_kind_t kind, logic prt,
                                logic [CH_W-1:0] ch, logic [DT_W-1:0] note,
                                logic [DT_W-1:0] ctl, logic [DT_W-1:0] val,
                                logic [SL_W-1:0] sl, logic [TM_W-1:0] ts);
        @(negedge clk);
        while (!quiet_run && $urandom_range(99) < 35)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {ts, sl, val, ctl, note, ch, prt};
        s_tuser  = kind;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(kind, prt, ch, note, ctl, val, sl, ts);
    endtask

    // random filler for the fields a request does not use
    task automatic send_play(logic prt, logic [CH_W-1:0] ch, logic [DT_W-1:0] note,
                             logic [DT_W-1:0] vel, logic [TM_W-1:0] ts);
        send_request(nsa_pkg::REQ_PLAY, prt, ch, note, DT_W'($urandom), vel,
                     SL_W'($urandom), ts);
    endtask

    task automatic send_stop(logic [SL_W-1:0] sl);
        send_request(nsa_pkg::REQ_STOP, 1'($urandom), CH_W'($urandom), DT_W'($urandom),
                     DT_W'($urandom), DT_W'($urandom), sl, $urandom);
    endtask

    task automatic send_cc(logic prt, logic [CH_W-1:0] ch, logic [DT_W-1:0] ctl,
                           logic [DT_W-1:0] val, logic [TM_W-1:0] ts);
        send_request(nsa_pkg::REQ_CC, prt, ch, DT_W'($urandom), ctl, val,
                     SL_W'($urandom), ts);
    endtask

    task automatic send_stop_all();
        send_request(nsa_pkg::REQ_ALL, 1'($urandom), CH_W'($urandom), DT_W'($urandom),
                     DT_W'($urandom), DT_W'($urandom), SL_W'($urandom), $urandom);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_ports(logic [1:0] mask);
        wait_drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = mask;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = 2'($urandom);
        ports_on  = mask;
    endtask

    function automatic logic [SL_W-1:0] pick_active_slot();
        int start;
        start = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
            if (slot_on[(start + i) % SLOTS])
                return SL_W'((start + i) % SLOTS);
        return SL_W'(start);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_disabled_ports();
        set_ports(2'b00);
        send_play(1'b0, 4'd3, 7'd60, 7'd100, 32'h0000_0001);
        send_play(1'b1, 4'd3, 7'd61, 7'd100, 32'h0000_0002);
        send_cc(1'b0, 4'd5, 7'd7, 7'd64, 32'h0000_0003);
        send_cc(1'b1, 4'd5, 7'd7, 7'd64, 32'h0000_0004);
        send_stop(6'd0);
        send_stop(6'd63);
        send_stop_all();
    endtask

    task automatic test_field_extremes();
        set_ports(2'b11);
        send_play(1'b1, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF);
        send_play(1'b0, 4'd0, 7'd0, 7'd0, 32'h0000_0000);
        send_cc(1'b1, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF);
        send_cc(1'b0, 4'd0, 7'd0, 7'd0, 32'h0000_0000);
        send_stop(6'd0);
        send_stop(6'd0);
        send_stop_all();
        send_stop_all();
    endtask

    // notes keep their recorded port after that port is switched off
    task automatic test_port_masks();
        set_ports(2'b01);
        send_play(1'b1, 4'd9, 7'd36, 7'd90, $urandom);
        send_cc(1'b1, 4'd9, 7'd1, 7'd10, $urandom);
        send_play(1'b0, 4'd9, 7'd38, 7'd91, $urandom);
        set_ports(2'b10);
        send_play(1'b0, 4'd2, 7'd40, 7'd92, $urandom);
        send_play(1'b1, 4'd2, 7'd42, 7'd93, $urandom);
        send_stop_all();
    endtask

    task automatic test_pool_full();
        set_ports(2'b11);
        while (!slot_on[pool_head])
            send_play(1'($urandom), CH_W'($urandom), DT_W'($urandom),
                      DT_W'($urandom), $urandom);
        repeat (2)
            send_play(1'($urandom), CH_W'($urandom), DT_W'($urandom),
                      DT_W'($urandom), $urandom);
        repeat (3)
            send_stop(SL_W'($urandom));
        repeat (4)
            send_play(1'($urandom), CH_W'($urandom), DT_W'($urandom),
                      DT_W'($urandom), $urandom);
        set_ports(2'b01);
        send_stop_all();
    endtask

    task automatic test_random_traffic(int count, logic [1:0] mask, bit steady,
                                       bit hold_mid);
        int  pick;
        logic prt;
        set_ports(mask);
        quiet_run = steady;
        for (int i = 0; i < count; i++)
        begin
            if (hold_mid && i == count / 2)
                wait_drain();
            pick = $urandom_range(99);
            prt  = 1'($urandom);
            // steer most requests to an enabled port
            if (mask != 2'b00 && !mask[prt] && $urandom_range(99) < 80)
                prt = ~prt;
            if (pick < 45)
                send_play(prt, CH_W'($urandom), DT_W'($urandom), DT_W'($urandom),
                          $urandom);
            else if (pick < 72)
                send_stop(($urandom_range(9) < 8) ? pick_active_slot()
                                                  : SL_W'($urandom));
            else if (pick < 94)
                send_cc(prt, CH_W'($urandom), DT_W'($urandom), DT_W'($urandom),
                        $urandom);
            else
                send_stop_all();
        end
        quiet_run = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = nsa_pkg::REQ_PLAY;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        quiet_run = 1'b0;
        err_count = 0;
        result_count = 0;
        n_req = 0; n_on = 0; n_off = 0; n_cc = 0; n_all = 0;
        n_port_off = 0; n_full = 0; n_idle_stop = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_on[i]   = 1'b0;
            slot_chan[i] = '0;
            slot_note[i] = '0;
            slot_prt[i]  = 1'b0;
            link_fwd[i]  = SL_W'((i + 1) % SLOTS);
            link_bwd[i]  = SL_W'((i + SLOTS - 1) % SLOTS);
        end
        pool_head = '0;
        ports_on  = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_disabled_ports();
        test_field_extremes();
        test_port_masks();
        test_pool_full();
        test_random_traffic(95, 2'b11, 1'b0, 1'b0);
        test_random_traffic(95, 2'b10, 1'b0, 1'b1);
        test_random_traffic(95, 2'b01, 1'b1, 1'b0);
        test_random_traffic(95, 2'b11, 1'b0, 1'b0);

        wait_drain();
        repeat (20) @(posedge clk);

        $display("Ran %0d requests, %0d results: %0d note-ons, %0d note-offs, %0d CCs,",
                 n_req, result_count, n_on, n_off, n_cc);
        $display("%0d stop-alls, %0d disabled-port rejects, %0d pool-full, %0d idle stops",
                 n_all, n_port_off, n_full, n_idle_stop);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
